// ===== hdl/osc_pkg.sv =====
// Shared constants, types and tables of the ozone concentration block.
package osc_pkg;

   localparam int ADC_IN_W  = 12;
   localparam int ADC_BITS  = 12;
   localparam int LRES_W    = 20;
   localparam int R0_W      = 24;
   localparam int TEMP_W    = 8;
   localparam int HUM_W     = 7;
   localparam int UNIT_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_LOAD_RES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_R0       = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MODEL    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP     = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_HUM      = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT     = CSR_IDX_W'(5);

   localparam logic [UNIT_W-1:0] UNIT_PPM  = UNIT_W'(0);
   localparam logic [UNIT_W-1:0] UNIT_PPB  = UNIT_W'(1);
   localparam logic [UNIT_W-1:0] UNIT_MG   = UNIT_W'(2);
   localparam logic [UNIT_W-1:0] UNIT_UG   = UNIT_W'(3);

   // Full-scale constant 2^ADC_BITS * 3.3 / 3.32 in Q16, rounded.
   localparam int          DIFF_W = ADC_BITS + 16;
   localparam logic [63:0] KQ     = ((64'd330 << DIFF_W) + 64'd166) / 64'd332;

   localparam int NUM_W    = LRES_W + DIFF_W;
   localparam int DVSR_W   = ADC_BITS + R0_W;
   localparam int RSQ_W    = NUM_W - 16;
   localparam int RS_W     = 32;
   localparam int RATIO_W  = 24;
   localparam int CORR_W   = 18;
   localparam int CONC_W   = 32;
   localparam int STEPS    = 16;
   localparam int MANT_W   = 31;
   localparam int Y_W      = 26;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [LRES_W-1:0]        load_resistance;
      logic [R0_W-1:0]          sensor_r0;
      logic                     sensor_model;
      logic signed [TEMP_W-1:0] temperature_c;
      logic [HUM_W-1:0]         humidity_pct;
      logic [UNIT_W-1:0]        out_unit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      load_resistance: LRES_W'(1000000),
      sensor_r0:       R0_W'(110471),
      sensor_model:    1'b0,
      temperature_c:   TEMP_W'(20),
      humidity_pct:    HUM_W'(60),
      out_unit:        UNIT_PPB
   };

   typedef struct packed {
      logic                fault;
      logic [ADC_BITS-1:0] s;
      logic [NUM_W-1:0]    num;
      logic [DVSR_W-1:0]   dvsr;
   } item_type;

   // Q30 constants 2^(2^-k) for k = 1..16.
   localparam logic [MANT_W-1:0] EXP_TAB [STEPS] = '{
      31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
      31'd1097253708, 31'd1085434105, 31'd1079572136, 31'd1076653033,
      31'd1075196444, 31'd1074468887, 31'd1074105294, 31'd1073923544,
      31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
   };

endpackage

// ===== hdl/osc_front.sv =====
// Front end: configuration registers, input transfer and sample classification.
module osc_front import osc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [ADC_IN_W-1:0]  req_adc_sample,
   output logic                 req_full,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata,
   output cfg_type              cfg,
   output logic                 q_push,
   output item_type             q_item,
   input  logic                 q_full
);

   cfg_type             cfg_ff, cfg_in;
   logic                f_vld_ff, f_vld_in;
   item_type            f_item_ff, f_item_in;
   logic                accept;
   logic [ADC_BITS-1:0] s;
   logic [DIFF_W-1:0]   s16, kq, diff;
   logic [R0_W-1:0]     r0;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LOAD_RES: cfg_in.load_resistance = csr_wdata[LRES_W-1:0];
            CSR_R0:       cfg_in.sensor_r0       = csr_wdata[R0_W-1:0];
            CSR_MODEL:    cfg_in.sensor_model    = csr_wdata[0];
            CSR_TEMP:     cfg_in.temperature_c   = csr_wdata[TEMP_W-1:0];
            CSR_HUM:      cfg_in.humidity_pct    = csr_wdata[HUM_W-1:0];
            CSR_UNIT:     cfg_in.out_unit        = csr_wdata[UNIT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_full = f_vld_ff & q_full;
   assign accept   = req_push & ~req_full;
   assign q_push   = f_vld_ff & ~q_full;
   assign f_vld_in = accept | (f_vld_ff & q_full);

   // A zero sample or one above full scale is a fault; the latter gives a negative resistance.
   always_comb begin
      s    = ADC_BITS'(req_adc_sample);
      s16  = {s, 16'd0};
      kq   = KQ[DIFF_W-1:0];
      diff = kq - s16;
      r0   = (cfg_ff.sensor_r0 == '0) ? R0_W'(1) : cfg_ff.sensor_r0;
      f_item_in.fault = (s == '0) || (s16 > kq);
      f_item_in.s     = s;
      f_item_in.num   = NUM_W'(cfg_ff.load_resistance) * NUM_W'(diff);
      f_item_in.dvsr  = DVSR_W'(s) * DVSR_W'(r0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         f_vld_ff <= 1'b0;
      end else begin
         cfg_ff   <= cfg_in;
         f_vld_ff <= f_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         f_item_ff <= f_item_in;
      end
   end

   assign cfg    = cfg_ff;
   assign q_item = f_item_ff;

endmodule

// ===== hdl/osc_queue.sv =====
// Short queue of classified items between the front end and the arithmetic pipeline.
module osc_queue import osc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type head
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full    = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign valid   = (cnt_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/osc_back.sv =====
// Arithmetic pipeline: dividers, correction, log2, power law, exp2 and result queue.
module osc_back import osc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              q_valid,
   input  item_type          q_head,
   output logic              q_pop,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output logic [RS_W-1:0]   rsp_rs_ohms,
   output logic [CONC_W-1:0] rsp_concentration,
   output logic              rsp_fault
);

   localparam int DIV_N  = RSQ_W + 1;
   localparam int LG_N   = STEPS + 1;
   localparam int XP_N   = STEPS + 1;
   localparam int N_ST   = DIV_N + 2 + LG_N + 1 + XP_N;
   localparam int PROD_W = RATIO_W + CORR_W;
   localparam int LP_W   = 40;
   localparam int OUT_DEPTH = 4;
   localparam int OPTR_W    = $clog2(OUT_DEPTH);
   localparam int HUM_HIGH  = 75;
   localparam int HUM_MID   = 50;
   localparam int HUM_NOM   = 60;
   localparam int TEMP_NOM  = 20;

   localparam logic signed [Y_W-1:0] LOG2_1000   = Y_W'(653118);
   localparam logic signed [Y_W-1:0] LOG2_MGCONV = Y_W'(70755);
   localparam logic signed [Y_W-1:0] COEF_LOW    = Y_W'(215257);
   localparam logic signed [Y_W-1:0] COEF_HIGH   = Y_W'(198247);
   localparam logic signed [Y_W-1:0] Q24_8_BIAS  = Y_W'(8 * 65536);
   localparam logic signed [18:0]    EXPO_LOW    = -19'sd147502;
   localparam logic signed [18:0]    EXPO_HIGH   = 19'sd152679;

   typedef struct packed {
      logic                fault;
      logic                sat;
      logic [ADC_BITS-1:0] rs_rem;
      logic [RSQ_W-1:0]    rs_q;
      logic [ADC_BITS-1:0] s;
      logic [DVSR_W-1:0]   ra_rem;
      logic [RATIO_W-1:0]  ra_q;
      logic [DVSR_W-1:0]   dvsr;
   } div_type;

   typedef struct packed {
      logic              fault;
      logic [RS_W-1:0]   rs;
      logic [PROD_W-1:0] prod;
   } cm_type;

   typedef struct packed {
      logic               fault;
      logic [RS_W-1:0]    rs;
      logic [RATIO_W-1:0] corr;
      logic               czero;
      logic [4:0]         p;
   } cz_type;

   typedef struct packed {
      logic              fault;
      logic              czero;
      logic [RS_W-1:0]   rs;
      logic [4:0]        p;
      logic [MANT_W-1:0] m;
      logic [STEPS-1:0]  frac;
   } lg_type;

   typedef struct packed {
      logic                   fault;
      logic                   czero;
      logic [RS_W-1:0]        rs;
      logic signed [LP_W-1:0] lp;
   } e1_type;

   typedef struct packed {
      logic              fault;
      logic              czero;
      logic [RS_W-1:0]   rs;
      logic              under;
      logic              over;
      logic [4:0]        n;
      logic [STEPS-1:0]  f;
      logic [MANT_W-1:0] m;
   } xp_type;

   typedef struct packed {
      logic [RS_W-1:0]   rs;
      logic [CONC_W-1:0] conc;
      logic              fault;
   } rsp_type;

   logic                    adv;
   logic [N_ST-1:0]         vld_ff, vld_in;
   div_type                 div_ff [DIV_N];
   div_type                 div_in [DIV_N];
   cm_type                  cm_ff, cm_in;
   cz_type                  cz_ff, cz_in;
   lg_type                  lg_ff [LG_N];
   lg_type                  lg_in [LG_N];
   e1_type                  e1_ff, e1_in;
   xp_type                  xp_ff [XP_N];
   xp_type                  xp_in [XP_N];
   logic [CORR_W-1:0]       corr_c;
   logic signed [Y_W-1:0]   unit_log;
   rsp_type                 out_mem_ff [OUT_DEPTH];
   rsp_type                 out_res;
   logic [OPTR_W-1:0]       owr_ff, owr_in, ord_ff, ord_in;
   logic [OPTR_W:0]         ocnt_ff, ocnt_in;
   logic                    out_push, out_pop;

   // Temperature and humidity correction in Q16; set by configuration only.
   always_comb begin
      logic signed [19:0] a, b, cs;
      if (cfg.humidity_pct > HUM_W'(HUM_HIGH)) begin
         a = 20'sd924;
         b = 20'sd102387;
      end else if (cfg.humidity_pct > HUM_W'(HUM_MID)) begin
         a = 20'sd780;
         b = 20'sd86907;
      end else begin
         a = 20'sd675;
         b = 20'sd75411;
      end
      cs = b - a * 20'(cfg.temperature_c);
      if ((cfg.humidity_pct == HUM_W'(HUM_NOM)) && (cfg.temperature_c == TEMP_W'(TEMP_NOM))) begin
         corr_c = CORR_W'(65536);
      end else if (cs < 0) begin
         corr_c = '0;
      end else begin
         corr_c = cs[CORR_W-1:0];
      end
   end

   always_comb begin
      unique case (cfg.out_unit)
         UNIT_PPM: unit_log = cfg.sensor_model ? '0 : -LOG2_1000;
         UNIT_PPB: unit_log = cfg.sensor_model ? LOG2_1000 : '0;
         UNIT_MG:  unit_log = cfg.sensor_model ? LOG2_MGCONV : LOG2_MGCONV - LOG2_1000;
         UNIT_UG:  unit_log = cfg.sensor_model ? LOG2_MGCONV + LOG2_1000 : LOG2_MGCONV;
         default:  unit_log = '0;
      endcase
   end

   // The whole pipeline moves together while the result queue has room.
   assign adv    = (ocnt_ff != (OPTR_W+1)'(OUT_DEPTH));
   assign q_pop  = adv & q_valid;
   assign vld_in = {vld_ff[N_ST-2:0], q_valid};

   // Two restoring dividers, one quotient bit per stage: rs = (num/2^16)/s and
   // ratio = num/(s*R0). The ratio saturates when its quotient needs more than 24 bits.
   always_comb begin
      logic [ADC_BITS:0] t_rs;
      logic [DVSR_W:0]   t_ra;
      logic              qb;
      div_in[0].fault  = q_head.fault;
      div_in[0].sat    = DVSR_W'(q_head.num[NUM_W-1:RATIO_W]) >= q_head.dvsr;
      div_in[0].rs_rem = '0;
      div_in[0].rs_q   = q_head.num[NUM_W-1:16];
      div_in[0].s      = q_head.s;
      div_in[0].ra_rem = DVSR_W'(q_head.num[NUM_W-1:RATIO_W]);
      div_in[0].ra_q   = q_head.num[RATIO_W-1:0];
      div_in[0].dvsr   = q_head.dvsr;
      for (int k = 1; k < DIV_N; k++) begin
         div_in[k] = div_ff[k-1];
         t_rs = {div_ff[k-1].rs_rem, div_ff[k-1].rs_q[RSQ_W-1]};
         qb   = (t_rs >= {1'b0, div_ff[k-1].s});
         div_in[k].rs_rem = qb ? ADC_BITS'(t_rs - {1'b0, div_ff[k-1].s}) : t_rs[ADC_BITS-1:0];
         div_in[k].rs_q   = {div_ff[k-1].rs_q[RSQ_W-2:0], qb};
         if (k <= RATIO_W) begin
            t_ra = {div_ff[k-1].ra_rem, div_ff[k-1].ra_q[RATIO_W-1]};
            qb   = (t_ra >= {1'b0, div_ff[k-1].dvsr});
            div_in[k].ra_rem = qb ? DVSR_W'(t_ra - {1'b0, div_ff[k-1].dvsr})
                                  : t_ra[DVSR_W-1:0];
            div_in[k].ra_q   = {div_ff[k-1].ra_q[RATIO_W-2:0], qb};
         end
      end
   end

   always_comb begin
      logic [RATIO_W-1:0] ratio;
      ratio       = div_ff[DIV_N-1].sat ? '1 : div_ff[DIV_N-1].ra_q;
      cm_in.fault = div_ff[DIV_N-1].fault;
      cm_in.rs    = RS_W'(div_ff[DIV_N-1].rs_q);
      cm_in.prod  = PROD_W'(ratio) * PROD_W'(corr_c);
   end

   always_comb begin
      cz_in.fault = cm_ff.fault;
      cz_in.rs    = cm_ff.rs;
      cz_in.corr  = (cm_ff.prod[PROD_W-1:RATIO_W+16] != '0) ? '1 : cm_ff.prod[RATIO_W+15:16];
      cz_in.czero = (cz_in.corr == '0);
      cz_in.p     = '0;
      for (int i = 0; i < RATIO_W; i++) begin
         if (cz_in.corr[i]) begin
            cz_in.p = 5'(i);
         end
      end
   end

   // log2 in Q16: integer part from the leading one, fraction by repeated squaring.
   always_comb begin
      logic [2*MANT_W-1:0] sq;
      logic [MANT_W:0]     sqs;
      lg_in[0].fault = cz_ff.fault;
      lg_in[0].czero = cz_ff.czero;
      lg_in[0].rs    = cz_ff.rs;
      lg_in[0].p     = cz_ff.p;
      lg_in[0].m     = MANT_W'(cz_ff.corr) << (5'd30 - cz_ff.p);
      lg_in[0].frac  = '0;
      for (int k = 1; k < LG_N; k++) begin
         lg_in[k] = lg_ff[k-1];
         sq  = (2*MANT_W)'(lg_ff[k-1].m) * (2*MANT_W)'(lg_ff[k-1].m);
         sqs = sq[2*MANT_W-1:30];
         if (sqs[MANT_W]) begin
            lg_in[k].frac[STEPS-k] = 1'b1;
            lg_in[k].m = sqs[MANT_W:1];
         end else begin
            lg_in[k].m = sqs[MANT_W-1:0];
         end
      end
   end

   always_comb begin
      logic signed [20:0] lr;
      logic signed [18:0] ex;
      lr = {5'(lg_ff[LG_N-1].p - 5'd16), lg_ff[LG_N-1].frac};
      ex = cfg.sensor_model ? EXPO_HIGH : EXPO_LOW;
      e1_in.fault = lg_ff[LG_N-1].fault;
      e1_in.czero = lg_ff[LG_N-1].czero;
      e1_in.rs    = lg_ff[LG_N-1].rs;
      e1_in.lp    = LP_W'(lr) * LP_W'(ex);
   end

   // exp2: integer part is a shift, fraction is a product of table constants.
   always_comb begin
      logic signed [LP_W-1:0] lps;
      logic signed [Y_W-1:0]  y;
      logic [2*MANT_W-1:0]    pr;
      lps = e1_ff.lp >>> 16;
      y   = (cfg.sensor_model ? COEF_HIGH : COEF_LOW) + Y_W'(lps) + unit_log + Q24_8_BIAS;
      xp_in[0].fault = e1_ff.fault;
      xp_in[0].czero = e1_ff.czero;
      xp_in[0].rs    = e1_ff.rs;
      xp_in[0].under = y[Y_W-1];
      xp_in[0].over  = ~y[Y_W-1] & (y[Y_W-2:21] != '0);
      xp_in[0].n     = y[20:16];
      xp_in[0].f     = y[15:0];
      xp_in[0].m     = MANT_W'(1 << 30);
      for (int k = 1; k < XP_N; k++) begin
         xp_in[k] = xp_ff[k-1];
         pr = (2*MANT_W)'(xp_ff[k-1].m) * (2*MANT_W)'(EXP_TAB[k-1]);
         if (xp_ff[k-1].f[STEPS-k]) begin
            xp_in[k].m = MANT_W'(pr >> 30);
         end
      end
   end

   always_comb begin
      xp_type x;
      x = xp_ff[XP_N-1];
      out_res.fault = x.fault;
      out_res.rs    = x.fault ? '0 : x.rs;
      priority if (x.fault) begin
         out_res.conc = '0;
      end else if (x.czero) begin
         out_res.conc = cfg.sensor_model ? '0 : '1;
      end else if (x.under) begin
         out_res.conc = '0;
      end else if (x.over) begin
         out_res.conc = '1;
      end else if (x.n <= 5'd30) begin
         out_res.conc = CONC_W'(x.m >> (5'd30 - x.n));
      end else begin
         out_res.conc = {x.m, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_N; k++) begin
            div_ff[k] <= div_in[k];
         end
         cm_ff <= cm_in;
         cz_ff <= cz_in;
         for (int k = 0; k < LG_N; k++) begin
            lg_ff[k] <= lg_in[k];
         end
         e1_ff <= e1_in;
         for (int k = 0; k < XP_N; k++) begin
            xp_ff[k] <= xp_in[k];
         end
      end
   end

   // Result queue.
   assign out_push  = adv & vld_ff[N_ST-1];
   assign out_pop   = rsp_pop & ~rsp_empty;
   assign rsp_empty = (ocnt_ff == '0);

   always_comb begin
      owr_in  = out_push ? owr_ff + OPTR_W'(1) : owr_ff;
      ord_in  = out_pop  ? ord_ff + OPTR_W'(1) : ord_ff;
      ocnt_in = ocnt_ff + (OPTR_W+1)'(out_push) - (OPTR_W+1)'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (adv) begin
            vld_ff <= vld_in;
         end
         owr_ff  <= owr_in;
         ord_ff  <= ord_in;
         ocnt_ff <= ocnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[owr_ff] <= out_res;
      end
   end

   assign rsp_rs_ohms       = out_mem_ff[ord_ff].rs;
   assign rsp_concentration = out_mem_ff[ord_ff].conc;
   assign rsp_fault         = out_mem_ff[ord_ff].fault;

endmodule

// ===== hdl/ozone_sensor_concentration.sv =====
// Top level of the ozone concentration block: front end, item queue and arithmetic pipeline.
//
//   Channel  Ports                               Transfer
//   request  req_push, req_full, req_adc_sample  req_push & !req_full
//   result   rsp_pop, rsp_empty, rsp_*           rsp_pop & !rsp_empty
//   config   csr_we, csr_index, csr_wdata        csr_we
//
// One sample is accepted per cycle while req_full is low; each result passes through the front
// register, the item queue and the 70-stage pipeline (divider, log2 and exp2 stages) into the result queue.
// Reset is synchronous and empties all queues; registered configuration reaches items in flight.
// A stalled result side halts the pipeline, then the item queue fills and req_full rises.
module ozone_sensor_concentration import osc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [ADC_IN_W-1:0]  req_adc_sample,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [RS_W-1:0]      rsp_rs_ohms,
   output logic [CONC_W-1:0]    rsp_concentration,
   output logic                 rsp_fault,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   cfg_type  cfg;
   logic     q_push, q_full, q_pop, q_valid;
   item_type q_item, q_head;

   osc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_adc_sample (req_adc_sample),
      .req_full       (req_full),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cfg            (cfg),
      .q_push         (q_push),
      .q_item         (q_item),
      .q_full         (q_full)
   );

   osc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   osc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_valid           (q_valid),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_rs_ohms       (rsp_rs_ohms),
      .rsp_concentration (rsp_concentration),
      .rsp_fault         (rsp_fault)
   );

endmodule

// ===== hdl/osc_checker.sv =====
// Port-level assertions for the ozone concentration block and their binding.
module osc_checker import osc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_full,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input logic [RS_W-1:0]      rsp_rs_ohms,
   input logic [CONC_W-1:0]    rsp_concentration,
   input logic                 rsp_fault
);

   // A waiting result stays put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_rs_ohms)
         && $stable(rsp_concentration) && $stable(rsp_fault))
      else $error("result changed while waiting");

   // The result queue only drains through a transfer.
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("result vanished without a transfer");

   // A faulty sample reports zero resistance and zero concentration.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_fault |-> rsp_rs_ohms == '0 && rsp_concentration == '0)
      else $error("fault result carries nonzero data");

   // Reset leaves both sides empty and ready.
   a_reset_state: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

endmodule

bind ozone_sensor_concentration osc_checker u_osc_checker (.*);

// ===== verif/ozone_sensor_concentration_test.sv =====
// Self-checking testbench of the ozone concentration block, driven through its queue and configuration ports.
`timescale 1ns / 100ps

module ozone_sensor_concentration_test;
   import osc_pkg::*;

   typedef struct packed {
      logic [RS_W-1:0]   rs_ohms;
      logic [CONC_W-1:0] concentration;
      logic              fault;
   } reading_type;

   typedef struct {
      logic [ADC_IN_W-1:0] sample;
      bit                  typed;
      reading_type         want;
   } stim_row_type;

   localparam int PHASES     = 11;
   localparam int PER_PHASE  = 68;
   localparam int CALM_PHASE = 5;
   localparam int DRAIN      = 100;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   logic [ADC_IN_W-1:0]  req_adc_sample = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   logic [RS_W-1:0]      rsp_rs_ohms;
   logic [CONC_W-1:0]    rsp_concentration;
   logic                 rsp_fault;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   cfg_type     settings = CFG_RESET;
   reading_type pending_readings[$];
   bit          calm = 1'b0;
   int          mismatches = 0;
   int          readings_checked = 0;
   int          faults_seen = 0;

   ozone_sensor_concentration dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Rows with a typed result are read straight off the fault rules.
   stim_row_type stim_rows[14] = '{
      '{12'd0,    1'b1, '{32'd0, 32'd0, 1'b1}},
      '{12'd4095, 1'b1, '{32'd0, 32'd0, 1'b1}},
      '{12'd4072, 1'b1, '{32'd0, 32'd0, 1'b1}},
      '{12'd4071, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd1,    1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd2,    1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd2048, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd100,  1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd3000, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd4000, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'hAAA,  1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'h555,  1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd1000, 1'b0, '{32'd0, 32'd0, 1'b0}},
      '{12'd3700, 1'b0, '{32'd0, 32'd0, 1'b0}}
   };

   cfg_type phase_cfgs[PHASES] = '{
      CFG_RESET,
      '{20'd1,       24'd1,        1'b0, 8'sd20,     7'd60,  UNIT_PPM},
      '{20'd1000000, 24'hFFFFFF,   1'b1, -8'sd40,    7'd0,   UNIT_PPB},
      '{20'd500000,  24'd0,        1'b1, 8'sd85,     7'd100, UNIT_MG},
      '{20'hFFFFF,   24'd22,       1'b0, -8'sd128,   7'd127, UNIT_UG},
      '{20'd10000,   24'd5000,     1'b0, 8'sd127,    7'd76,  UNIT_MG},
      '{20'd1000000, 24'd110471,   1'b1, 8'sd20,     7'd60,  UNIT_PPM},
      '{20'd33333,   24'd200000,   1'b0, 8'sd0,      7'd50,  UNIT_UG},
      '{20'd777,     24'd1,        1'b1, 8'sd121,    7'd90,  UNIT_PPB},
      CFG_RESET,
      CFG_RESET
   };

   function automatic reading_type predict_reading(logic [ADC_IN_W-1:0] sample, cfg_type c);
      reading_type r;
      longint unsigned s, s16, diff, num, rs, r0, ratio, corr, m;
      longint          cq, a, b, lr, total;
      int              p, n, k;
      longint          frac;
      s = longint'(sample[ADC_BITS-1:0]);
      s16 = s << 16;
      r = '0;
      if (s == 0 || s16 > KQ) begin
         r.fault = 1'b1;
         return r;
      end
      diff = KQ - s16;
      num = longint'(c.load_resistance) * diff;
      rs = num / s16;
      r.rs_ohms = (rs > 64'hFFFFFFFF) ? 32'hFFFFFFFF : rs[31:0];
      r0 = (c.sensor_r0 == 0) ? 1 : longint'(c.sensor_r0);
      ratio = num / (s * r0);
      if (ratio > 64'hFFFFFF) ratio = 64'hFFFFFF;
      if (c.humidity_pct == 60 && c.temperature_c == 20) begin
         cq = 65536;
      end else begin
         if (c.humidity_pct > 75) begin
            a = 924; b = 102387;
         end else if (c.humidity_pct > 50) begin
            a = 780; b = 86907;
         end else begin
            a = 675; b = 75411;
         end
         cq = b - a * longint'($signed(c.temperature_c));
         if (cq < 0) cq = 0;
      end
      corr = (ratio * longint'(cq)) >> 16;
      if (corr > 64'hFFFFFF) corr = 64'hFFFFFF;
      if (corr == 0) begin
         r.concentration = c.sensor_model ? 32'd0 : 32'hFFFFFFFF;
         return r;
      end
      // log2 in Q16: leading one, then squaring of the Q30 mantissa.
      p = 31;
      while (p > 0 && !corr[p]) p--;
      m = (corr << 30) >> p;
      frac = 0;
      for (k = 15; k >= 0; k--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            frac |= longint'(1) << k;
            m >>= 1;
         end
      end
      lr = longint'(p - 16) * 65536 + frac;
      if (c.sensor_model) begin
         total = 198247 + ((lr * 152679) >>> 16);
         case (c.out_unit)
            UNIT_PPM: total += 0;
            UNIT_PPB: total += 653118;
            UNIT_MG:  total += 70755;
            default:  total += 70755 + 653118;
         endcase
      end else begin
         total = 215257 + ((lr * -147502) >>> 16);
         case (c.out_unit)
            UNIT_PPM: total += -653118;
            UNIT_PPB: total += 0;
            UNIT_MG:  total += 70755 - 653118;
            default:  total += 70755;
         endcase
      end
      total += 8 * 65536;
      if (total < 0) begin
         r.concentration = 32'd0;
      end else if (total >= 32 * 65536) begin
         r.concentration = 32'hFFFFFFFF;
      end else begin
         n = int'(total >> 16);
         m = 64'd1 << 30;
         for (k = 0; k < 16; k++)
            if (total[15-k]) m = (m * longint'(EXP_TAB[k])) >> 30;
         if (n <= 30) r.concentration = 32'(m >> (30 - n));
         else r.concentration = 32'(m << 1);
      end
      return r;
   endfunction

   task automatic send_sample(logic [ADC_IN_W-1:0] sample, bit typed, reading_type want);
      while (!calm && $urandom_range(99) < 23) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_adc_sample <= sample;
      do @(posedge clock); while (req_full);
      pending_readings.push_back(typed ? want : predict_reading(sample, settings));
   endtask

   task automatic write_settings(cfg_type c);
      logic [CSR_DAT_W-1:0] vals[6];
      vals[0] = {4'b0, c.load_resistance};
      vals[1] = c.sensor_r0;
      vals[2] = {23'b0, c.sensor_model};
      vals[3] = {16'b0, c.temperature_c};
      vals[4] = {17'b0, c.humidity_pct};
      vals[5] = {22'b0, c.out_unit};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings = c;
   endtask

   function automatic logic [ADC_IN_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) return '0;
      if (pick < 14) return ADC_IN_W'($urandom_range(4095));
      if (pick < 24) return ADC_IN_W'($urandom_range(64, 1));
      return ADC_IN_W'($urandom_range(4071, 1));
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.load_resistance = LRES_W'($urandom_range(1000000, 1));
      c.sensor_r0 = R0_W'($urandom_range(16777215, 1));
      c.sensor_model = 1'($urandom_range(1));
      c.temperature_c = TEMP_W'($urandom_range(255));
      c.humidity_pct = HUM_W'($urandom_range(127));
      c.out_unit = UNIT_W'($urandom_range(3));
      return c;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transfer: rs %0d conc %h fault %b",
                           rsp_rs_ohms, rsp_concentration, rsp_fault);
            end else begin
               reading_type want;
               want = pending_readings.pop_front();
               readings_checked++;
               if (want.fault) faults_seen++;
               if (rsp_rs_ohms !== want.rs_ohms || rsp_concentration !== want.concentration
                   || rsp_fault !== want.fault) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected rs %0d conc %h fault %b, got rs %0d conc %h fault %b",
                              want.rs_ohms, want.concentration, want.fault,
                              rsp_rs_ohms, rsp_concentration, rsp_fault);
               end
            end
         end
         rsp_pop <= calm ? 1'b1 : ($urandom_range(99) >= 23);
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < $size(stim_rows); i++)
         send_sample(stim_rows[i].sample, stim_rows[i].typed, stim_rows[i].want);
      for (int ph = 0; ph < PHASES; ph++) begin
         // The sender holds off here until the block has drained completely.
         req_push <= 1'b0;
         wait (pending_readings.size() == 0);
         repeat (DRAIN) @(posedge clock);
         if (ph > 0) write_settings(ph >= 9 ? random_settings() : phase_cfgs[ph]);
         calm = (ph == CALM_PHASE);
         for (int i = 0; i < PER_PHASE; i++)
            send_sample(random_sample(), 1'b0, '0);
      end
      req_push <= 1'b0;
      calm = 1'b0;
      wait (pending_readings.size() == 0);
      repeat (DRAIN) @(posedge clock);
      $display("Checked %0d readings (%0d faults) over %0d register settings,",
               readings_checked, faults_seen, PHASES);
      $display("covering both curves, all units and extreme resistor and climate values.");
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("ozone_sensor_concentration_test: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("ozone_sensor_concentration_test: errors");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout");
      $display("ozone_sensor_concentration_test: errors");
      $finish;
   end

endmodule
